>>> src/rds_pkg.sv
`timescale 1ns / 1ps

package rds_pkg;

   // Fixed field widths of the coefficient path (Q1.24 registers)
   localparam int COEF_W    = 25;
   localparam int COEF_FRAC = 24;
   localparam int D_W       = 26;          // local diffusivity
   localparam int DLO_W     = 13;          // low half of Dl for the split multiply
   localparam int Q_W       = 27;          // harmonic mean quotient and face sum
   localparam int N_W       = 2 * D_W + 1; // 2*Dn*Dl

   // Register indexes on the CSR port
   localparam logic [1:0] CSR_COEF_WHITE = 2'd0;
   localparam logic [1:0] CSR_COEF_GREY  = 2'd1;
   localparam logic [1:0] CSR_GROWTH     = 2'd2;
   localparam logic [1:0] CSR_SMALL_SUM  = 2'd3;

   // Datapath operations
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE   = 4'd0;
   localparam op_type OP_ACCEPT = 4'd1;
   localparam op_type OP_READ   = 4'd2;
   localparam op_type OP_MUL_W  = 4'd3;
   localparam op_type OP_MUL_G  = 4'd4;
   localparam op_type OP_GF     = 4'd5;
   localparam op_type OP_HM_LO  = 4'd6;
   localparam op_type OP_HM_HI  = 4'd7;
   localparam op_type OP_DIV    = 4'd8;
   localparam op_type OP_FACE   = 4'd9;
   localparam op_type OP_ACC    = 4'd10;
   localparam op_type OP_GROW   = 4'd11;
   localparam op_type OP_OUT    = 4'd12;

   // Stencil cell selects: center, then the six neighbours in pairs
   typedef logic [2:0] sel_type;
   localparam sel_type SEL_CENTER = 3'd0;
   localparam sel_type SEL_XM     = 3'd1;
   localparam sel_type SEL_XP     = 3'd2;
   localparam sel_type SEL_YM     = 3'd3;
   localparam sel_type SEL_YP     = 3'd4;
   localparam sel_type SEL_ZM     = 3'd5;
   localparam sel_type SEL_ZP     = 3'd6;

   typedef struct packed {
      op_type  op;
      sel_type sel;
   } rds_cmd_type;

   typedef struct packed {
      logic interior;
      logic center_zero;
      logic out_free;
   } rds_status_type;

endpackage

>>> src/rds_ctrl.sv
`timescale 1ns / 1ps

module rds_ctrl import rds_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  rds_status_type status,
   output rds_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_READ = 4'd1;
   localparam logic [3:0] ST_MULW = 4'd2;
   localparam logic [3:0] ST_MULG = 4'd3;
   localparam logic [3:0] ST_GF   = 4'd4;
   localparam logic [3:0] ST_HLO  = 4'd5;
   localparam logic [3:0] ST_HHI  = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_FACE = 4'd8;
   localparam logic [3:0] ST_ACC  = 4'd9;
   localparam logic [3:0] ST_GROW = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   localparam int CW = $clog2(Q_W);

   logic [3:0]    state_ff, state_in;
   sel_type       sel_ff, sel_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               if (status.interior) begin
                  sel_in   = SEL_CENTER;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.op   = OP_READ;
            state_in = ST_MULW;
         end
         ST_MULW: begin
            cmd.op   = OP_MUL_W;
            state_in = ST_MULG;
         end
         ST_MULG: begin
            cmd.op = OP_MUL_G;
            if (sel_ff != SEL_CENTER) begin
               state_in = ST_HLO;
            end else if (status.center_zero) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_GF;
            end
         end
         ST_GF: begin
            cmd.op   = OP_GF;
            sel_in   = SEL_XM;
            state_in = ST_READ;
         end
         ST_HLO: begin
            cmd.op   = OP_HM_LO;
            state_in = ST_HHI;
         end
         ST_HHI: begin
            cmd.op   = OP_HM_HI;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(Q_W - 1)) begin
               state_in = ST_FACE;
            end
         end
         ST_FACE: begin
            cmd.op = OP_FACE;
            if (sel_ff == SEL_ZP) begin
               sel_in   = SEL_XM;
               state_in = ST_ACC;
            end else begin
               sel_in   = sel_ff + 3'd1;
               state_in = ST_READ;
            end
         end
         ST_ACC: begin
            cmd.op = OP_ACC;
            if (sel_ff == SEL_ZP) begin
               state_in = ST_GROW;
            end else begin
               sel_in = sel_ff + 3'd1;
            end
         end
         ST_GROW: begin
            cmd.op   = OP_GROW;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_CENTER;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> src/rds_dpath.sv
`timescale 1ns / 1ps

module rds_dpath import rds_pkg::*; #(
   parameter int BLOCK_EDGE = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [COEF_W-1:0]    coef_white,
   input  logic [COEF_W-1:0]    coef_grey,
   input  logic [COEF_W-1:0]    growth,
   input  logic [COEF_W-1:0]    small_sum_limit,
   input  logic [FRAC_BITS:0]   req_white_frac,
   input  logic [FRAC_BITS:0]   req_grey_frac,
   input  logic [FRAC_BITS:0]   req_tumor,
   input  rds_cmd_type          cmd,
   output rds_status_type       status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [FRAC_BITS:0]   rsp_new_tumor,
   output logic                 rsp_last_of_block
);

   localparam int PE     = BLOCK_EDGE + 2;
   localparam int PLANE  = PE * PE;
   localparam int DEPTH  = 2 * PLANE + 1;
   localparam int AW     = $clog2(DEPTH);
   localparam int PW     = $clog2(PE);
   localparam int FW     = FRAC_BITS + 1;
   localparam int CELL_W = 3 * FW;
   localparam int P1_W   = FW + COEF_W;
   localparam int ACC_W  = FRAC_BITS + 36;
   localparam int EMPTY_LIMIT = ((2 ** FRAC_BITS) + 5) / 10;
   localparam logic [FW-1:0] ONE_FRAC = {1'b1, {FRAC_BITS{1'b0}}};

   function automatic logic [FW-1:0] sat_one(input logic [FW-1:0] v);
      sat_one = (v > ONE_FRAC) ? ONE_FRAC : v;
   endfunction

   // position and window pointers
   logic [PW-1:0] x_ff, y_ff, z_ff;
   logic [AW-1:0] wr_ff, ctr_ff;
   logic          last_pad, last_int;

   // window store and read data
   logic [CELL_W-1:0] win_ff [DEPTH];
   logic [CELL_W-1:0] rdata_ff;
   logic [AW-1:0]     rd_addr;
   logic [AW:0]       off, up_sum;
   logic              dir_up;
   logic [FW-1:0]     rd_w, rd_g, rd_t;

   // arithmetic registers
   logic [P1_W-1:0]          p1_ff;
   logic [D_W-1:0]           dl_ff, dn_ff;
   logic [FW-1:0]            phi_ff;
   logic                     center_zero_ff;
   logic [FRAC_BITS-1:0]     gf_ff;
   logic [D_W+DLO_W-1:0]     plo_ff;
   logic [Q_W-1:0]           sum_ff, quo_ff, rem_ff;
   logic [Q_W-1:0]           face_ff [6];
   logic [FW-1:0]            tnb_ff [6];
   logic                     empty_ff [6];
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     last_ff;

   logic                     rsp_valid_ff;
   logic [FW-1:0]            new_tumor_ff;
   logic                     last_out_ff;

   // combinational helpers
   logic [2:0]               k, kp;
   logic [P1_W-1:0]          p1_in, p2;
   logic [P1_W:0]            dsum;
   logic [D_W-1:0]           d_in;
   logic [FW:0]              esum;
   logic [2*FW-1:0]          gprod;
   logic [D_W+DLO_W-1:0]     phi_prod;
   logic [N_W-2:0]           prod;
   logic [N_W-1:0]           numer;
   logic [Q_W:0]             trial;
   logic                     ge;
   logic                     face_zero;
   logic signed [Q_W+1:0]    f_s;
   logic signed [FW:0]       dt;
   logic signed [Q_W+FW+2:0] aprod;
   logic [COEF_W+FRAC_BITS-1:0] grow_prod;
   logic signed [ACC_W-1:0]  rsum, delta, res;
   logic [FW-1:0]            clamped;

   assign last_pad = (x_ff == PW'(PE - 1)) && (y_ff == PW'(PE - 1)) && (z_ff == PW'(PE - 1));
   assign last_int = (x_ff == PW'(BLOCK_EDGE)) && (y_ff == PW'(BLOCK_EDGE))
                     && (z_ff == PW'(BLOCK_EDGE + 1));

   assign status.interior = (x_ff != '0) && (x_ff <= PW'(BLOCK_EDGE))
                            && (y_ff != '0) && (y_ff <= PW'(BLOCK_EDGE))
                            && (z_ff >= PW'(2)) && (z_ff <= PW'(BLOCK_EDGE + 1));
   assign status.center_zero = center_zero_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   // neighbour address modulo the window depth
   always_comb begin
      case (cmd.sel)
         SEL_XM, SEL_XP: off = (AW+1)'(1);
         SEL_YM, SEL_YP: off = (AW+1)'(PE);
         SEL_ZM, SEL_ZP: off = (AW+1)'(PLANE);
         default:        off = '0;
      endcase
      dir_up = (cmd.sel == SEL_XP) || (cmd.sel == SEL_YP) || (cmd.sel == SEL_ZP);
      up_sum = {1'b0, ctr_ff} + off;
      if (dir_up) begin
         rd_addr = (up_sum >= (AW+1)'(DEPTH)) ? AW'(up_sum - (AW+1)'(DEPTH)) : AW'(up_sum);
      end else if ({1'b0, ctr_ff} >= off) begin
         rd_addr = AW'({1'b0, ctr_ff} - off);
      end else begin
         rd_addr = AW'({1'b0, ctr_ff} + (AW+1)'(DEPTH) - off);
      end
   end

   assign rd_w = rdata_ff[CELL_W-1 -: FW];
   assign rd_g = rdata_ff[2*FW-1 -: FW];
   assign rd_t = rdata_ff[FW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         win_ff[wr_ff] <= {sat_one(req_white_frac), sat_one(req_grey_frac), sat_one(req_tumor)};
      end
      if (cmd.op == OP_READ) begin
         rdata_ff <= win_ff[rd_addr];
      end
   end

   always_comb begin
      k         = cmd.sel - 3'd1;
      kp        = k ^ 3'd1;
      p1_in     = {{COEF_W{1'b0}}, rd_w} * {{FW{1'b0}}, coef_white};
      p2        = {{COEF_W{1'b0}}, rd_g} * {{FW{1'b0}}, coef_grey};
      dsum      = {1'b0, p1_ff} + {1'b0, p2} + (P1_W+1)'(2 ** (FRAC_BITS - 1));
      d_in      = dsum[FRAC_BITS +: D_W];
      esum      = {1'b0, rd_t} + {1'b0, rd_w} + {1'b0, rd_g};
      gprod     = {{FW{1'b0}}, phi_ff} * {{FW{1'b0}}, ONE_FRAC - phi_ff};
      phi_prod  = {{DLO_W{1'b0}}, dn_ff} * {{D_W{1'b0}}, dl_ff[D_W-1:DLO_W]};
      prod      = {{(N_W-1-D_W-DLO_W){1'b0}}, plo_ff}
                  + {phi_prod[N_W-2-DLO_W:0], {DLO_W{1'b0}}};
      numer     = {prod, 1'b0};
      trial     = {rem_ff, quo_ff[Q_W-1]};
      ge        = trial >= {1'b0, sum_ff};
      face_zero = (sum_ff == '0) || (sum_ff < {{(Q_W-COEF_W){1'b0}}, small_sum_limit});
      f_s       = empty_ff[kp] ? $signed({1'b0, face_ff[k], 1'b0})
                               : $signed({2'b00, face_ff[k]});
      dt        = $signed({1'b0, tnb_ff[k]}) - $signed({1'b0, phi_ff});
      aprod     = f_s * dt;
      grow_prod = {{FRAC_BITS{1'b0}}, growth} * {{COEF_W{1'b0}}, gf_ff};
      rsum      = acc_ff + ACC_W'(2 ** (COEF_FRAC - 1));
      delta     = rsum >>> COEF_FRAC;
      res       = $signed(ACC_W'(phi_ff)) + delta;
      if (res < 0) begin
         clamped = '0;
      end else if (res > $signed(ACC_W'(ONE_FRAC))) begin
         clamped = ONE_FRAC;
      end else begin
         clamped = res[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_ACCEPT: begin
            last_ff <= last_int;
            ctr_ff  <= (wr_ff >= AW'(PLANE)) ? wr_ff - AW'(PLANE) : wr_ff + AW'(PLANE + 1);
         end
         OP_MUL_W: begin
            p1_ff <= p1_in;
            if (cmd.sel == SEL_CENTER) begin
               phi_ff         <= rd_t;
               center_zero_ff <= (rd_w == '0) && (rd_g == '0) && (rd_t == '0);
            end else begin
               tnb_ff[k]   <= rd_t;
               empty_ff[k] <= esum < (FW+1)'(EMPTY_LIMIT);
            end
         end
         OP_MUL_G: begin
            if (cmd.sel == SEL_CENTER) begin
               dl_ff <= d_in;
            end else begin
               dn_ff <= d_in;
            end
         end
         OP_GF: begin
            gf_ff  <= gprod[FRAC_BITS +: FRAC_BITS];
            acc_ff <= '0;
         end
         OP_HM_LO: begin
            plo_ff <= {{DLO_W{1'b0}}, dn_ff} * {{D_W{1'b0}}, dl_ff[DLO_W-1:0]};
            sum_ff <= {1'b0, dn_ff} + {1'b0, dl_ff};
         end
         OP_HM_HI: begin
            // quotient fits Q_W bits, so the top bits already sit below the divisor
            rem_ff <= {1'b0, numer[N_W-1:Q_W]};
            quo_ff <= numer[Q_W-1:0];
         end
         OP_DIV: begin
            rem_ff <= ge ? Q_W'(trial - {1'b0, sum_ff}) : trial[Q_W-1:0];
            quo_ff <= {quo_ff[Q_W-2:0], ge};
         end
         OP_FACE: begin
            face_ff[k] <= face_zero ? '0 : quo_ff;
         end
         OP_ACC: begin
            acc_ff <= acc_ff + ACC_W'(aprod);
         end
         OP_GROW: begin
            acc_ff <= acc_ff + $signed(ACC_W'(grow_prod));
         end
         OP_OUT: begin
            new_tumor_ff <= center_zero_ff ? phi_ff : clamped;
            last_out_ff  <= last_ff;
         end
         default: begin
         end
      endcase
   end

   // position counters and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= '0;
         wr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_ACCEPT) begin
            if (x_ff == PW'(PE - 1)) begin
               x_ff <= '0;
               if (y_ff == PW'(PE - 1)) begin
                  y_ff <= '0;
                  z_ff <= (z_ff == PW'(PE - 1)) ? '0 : z_ff + PW'(1);
               end else begin
                  y_ff <= y_ff + PW'(1);
               end
            end else begin
               x_ff <= x_ff + PW'(1);
            end
            wr_ff <= (last_pad || wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
         end
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_tumor     = new_tumor_ff;
   assign rsp_last_of_block = last_out_ff;

endmodule

>>> src/reaction_diffusion_stencil_step_unit.sv
`timescale 1ns / 1ps

// Fisher-KPP reaction-diffusion step over one padded cubic block. Stream all
// (BLOCK_EDGE+2)^3 cells of the block, halo included, in raster order (x
// fastest, then y, then z); each cell carries white, grey and tumor values in
// Q1.FRAC_BITS, saturated to one on entry. Every cell that completes the
// 7-point stencil of an interior cell returns that cell's updated tumor
// density, clamped to [0,1], with last_of_block set on the final interior
// cell; halo-completing cells return nothing. A halo cell is only stored; an
// interior cell whose center is empty returns its tumor value unchanged. For
// any other interior cell each stencil cell is read from the single-port
// window memory and its local diffusivity formed, six harmonic-mean divisions
// run on one shared divider of 27 one-bit steps, then come the accumulate and
// round. The input is stalled while an item is in work; a finished result
// sits in the output register so the next item can enter while it waits.
// Write the Q1.24 coefficients over the CSR port only while the unit is idle.

module reaction_diffusion_stencil_step_unit import rds_pkg::*; #(
   parameter int BLOCK_EDGE = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FRAC_BITS:0]   req_white_frac,
   input  logic [FRAC_BITS:0]   req_grey_frac,
   input  logic [FRAC_BITS:0]   req_tumor,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [FRAC_BITS:0]   rsp_new_tumor,
   output logic                 rsp_last_of_block,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   // Coefficient registers, Q1.24
   logic [COEF_W-1:0] coef_white_ff, coef_grey_ff, growth_ff, small_sum_ff;
   logic              csr_write;
   rds_cmd_type       cmd;
   rds_status_type    status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Register writes: each register owns one 32-bit word
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_white_ff <= COEF_W'(2768240);
         coef_grey_ff  <= COEF_W'(276824);
         growth_ff     <= '0;
         small_sum_ff  <= COEF_W'(1);
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            CSR_COEF_WHITE: coef_white_ff <= csr_pwdata[COEF_W-1:0];
            CSR_COEF_GREY:  coef_grey_ff  <= csr_pwdata[COEF_W-1:0];
            CSR_GROWTH:     growth_ff     <= csr_pwdata[COEF_W-1:0];
            CSR_SMALL_SUM:  small_sum_ff  <= csr_pwdata[COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_COEF_WHITE: csr_prdata = {{(32-COEF_W){1'b0}}, coef_white_ff};
         CSR_COEF_GREY:  csr_prdata = {{(32-COEF_W){1'b0}}, coef_grey_ff};
         CSR_GROWTH:     csr_prdata = {{(32-COEF_W){1'b0}}, growth_ff};
         CSR_SMALL_SUM:  csr_prdata = {{(32-COEF_W){1'b0}}, small_sum_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Sequencer: stores each item and steps interior items through reads, divisions, accumulate
   rds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Window memory, multipliers, shared divider, accumulator, output register
   rds_dpath #(
      .BLOCK_EDGE (BLOCK_EDGE),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .coef_white        (coef_white_ff),
      .coef_grey         (coef_grey_ff),
      .growth            (growth_ff),
      .small_sum_limit   (small_sum_ff),
      .req_white_frac    (req_white_frac),
      .req_grey_frac     (req_grey_frac),
      .req_tumor         (req_tumor),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_new_tumor     (rsp_new_tumor),
      .rsp_last_of_block (rsp_last_of_block)
   );

endmodule

>>> src/rds_checker.sv
`timescale 1ns / 1ps

module rds_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [FRAC_BITS:0] rsp_new_tumor,
   input logic               rsp_last_of_block
);

   localparam logic [FRAC_BITS:0] ONE_FRAC = {1'b1, {FRAC_BITS{1'b0}}};

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_tumor)
                                 && $stable(rsp_last_of_block))
      else $error("stalled result changed");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_new_tumor <= ONE_FRAC)
      else $error("new tumor above one");

   // a result only appears after the unit has been busy with its item
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an accepted item never yields a result on the next edge
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result too early");

endmodule

bind reaction_diffusion_stencil_step_unit rds_checker #(.FRAC_BITS(FRAC_BITS)) u_rds_checker (.*);
